// ===== hw/rtl/hs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hs_pkg
// Shared types and sizes for the heap sorter: request and result payloads and store depth.
// ----------------------------------------------------------------------------
package hs_pkg;

	localparam int MAX_ELEMENTS = 64;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               final_res;
		logic               overflowed;
	} result_t;

endpackage

// ===== hw/rtl/heap_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_sorter
// Collects signed values, heapsorts them in place and streams them out
// in ascending order, driven by a small microcode sequencer.
// ----------------------------------------------------------------------------
// Values are taken one per cycle into a 64-entry store until the request
// marked last closes the set; values beyond 64 are dropped and every result
// of that set then carries overflowed. The set is sorted with heapsort over
// the single store (two read ports, one write port); each sift level is a
// child read step and then a compare-and-move step, and each result then
// goes through wait, read, load and next steps. The last result is marked
// final_res, and a new set can start while that last result still waits to
// be taken.
module heap_sorter
	import hs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int PC_W = 5;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_COLLECT,
		OP_BINIT,
		OP_BREAD,
		OP_LOADN,
		OP_SREAD,
		OP_SCMP,
		OP_SINIT,
		OP_SWAPRD,
		OP_SWAPWR,
		OP_OINIT,
		OP_ORD,
		OP_OLOAD,
		OP_ONEXT,
		OP_CLEAR
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOT_CLOSE,
		C_I_ZERO,
		C_MOVED,
		C_OUT_BUSY,
		C_MORE
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} uword_t;

	localparam logic [PC_W-1:0] S_COLLECT = 5'd0;
	localparam logic [PC_W-1:0] S_BINIT   = 5'd1;
	localparam logic [PC_W-1:0] S_BTEST   = 5'd2;
	localparam logic [PC_W-1:0] S_BREAD   = 5'd3;
	localparam logic [PC_W-1:0] S_LOADN   = 5'd4;
	localparam logic [PC_W-1:0] S_BSREAD  = 5'd5;
	localparam logic [PC_W-1:0] S_BSCMP   = 5'd6;
	localparam logic [PC_W-1:0] S_BNEXT   = 5'd7;
	localparam logic [PC_W-1:0] S_SINIT   = 5'd8;
	localparam logic [PC_W-1:0] S_STEST   = 5'd9;
	localparam logic [PC_W-1:0] S_SWAPRD  = 5'd10;
	localparam logic [PC_W-1:0] S_SWAPWR  = 5'd11;
	localparam logic [PC_W-1:0] S_SSREAD  = 5'd12;
	localparam logic [PC_W-1:0] S_SSCMP   = 5'd13;
	localparam logic [PC_W-1:0] S_SNEXT   = 5'd14;
	localparam logic [PC_W-1:0] S_OINIT   = 5'd15;
	localparam logic [PC_W-1:0] S_OWAIT   = 5'd16;
	localparam logic [PC_W-1:0] S_ORD     = 5'd17;
	localparam logic [PC_W-1:0] S_OLOAD   = 5'd18;
	localparam logic [PC_W-1:0] S_ONEXT   = 5'd19;
	localparam logic [PC_W-1:0] S_CLEAR   = 5'd20;

	// control store: a conditional jump goes to target, otherwise to the next step
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			S_COLLECT: w = '{OP_COLLECT, C_NOT_CLOSE, S_COLLECT};
			S_BINIT:   w = '{OP_BINIT,   C_NEVER,     S_COLLECT};
			S_BTEST:   w = '{OP_NOP,     C_I_ZERO,    S_SINIT};
			S_BREAD:   w = '{OP_BREAD,   C_NEVER,     S_COLLECT};
			S_LOADN:   w = '{OP_LOADN,   C_NEVER,     S_COLLECT};
			S_BSREAD:  w = '{OP_SREAD,   C_NEVER,     S_COLLECT};
			S_BSCMP:   w = '{OP_SCMP,    C_MOVED,     S_BSREAD};
			S_BNEXT:   w = '{OP_NOP,     C_ALWAYS,    S_BTEST};
			S_SINIT:   w = '{OP_SINIT,   C_NEVER,     S_COLLECT};
			S_STEST:   w = '{OP_NOP,     C_I_ZERO,    S_OINIT};
			S_SWAPRD:  w = '{OP_SWAPRD,  C_NEVER,     S_COLLECT};
			S_SWAPWR:  w = '{OP_SWAPWR,  C_NEVER,     S_COLLECT};
			S_SSREAD:  w = '{OP_SREAD,   C_NEVER,     S_COLLECT};
			S_SSCMP:   w = '{OP_SCMP,    C_MOVED,     S_SSREAD};
			S_SNEXT:   w = '{OP_NOP,     C_ALWAYS,    S_STEST};
			S_OINIT:   w = '{OP_OINIT,   C_NEVER,     S_COLLECT};
			S_OWAIT:   w = '{OP_NOP,     C_OUT_BUSY,  S_OWAIT};
			S_ORD:     w = '{OP_ORD,     C_NEVER,     S_COLLECT};
			S_OLOAD:   w = '{OP_OLOAD,   C_NEVER,     S_COLLECT};
			S_ONEXT:   w = '{OP_ONEXT,   C_MORE,      S_OWAIT};
			S_CLEAR:   w = '{OP_CLEAR,   C_ALWAYS,    S_COLLECT};
			default:   w = '{OP_NOP,     C_ALWAYS,    S_COLLECT};
		endcase
		return w;
	endfunction

	logic [PC_W-1:0]    pc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   heap_q;
	logic [IDX_W-1:0]   node_q;
	logic signed [31:0] nval_q;
	logic               result_valid_q;
	result_t            result_q;

	logic signed [31:0] mem [MAX_ELEMENTS];
	logic signed [31:0] rd_a_q;
	logic signed [31:0] rd_b_q;

	uword_t             uw;
	logic               item_acc;
	logic               take;
	logic               jump;
	logic [IDX_W-1:0]   raddr_a;
	logic [IDX_W-1:0]   raddr_b;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic signed [31:0] wdata;

	// sift compare
	logic [CNT_W:0]     lidx;
	logic [CNT_W:0]     ridx;
	logic [CNT_W:0]     top_idx;
	logic signed [31:0] top_val;
	logic               moved;

	assign uw         = ucode(pc_q);
	assign item_ready = (uw.op == OP_COLLECT);
	assign item_acc   = item_valid && item_ready;
	assign take       = result_valid_q && result_ready;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign lidx = {1'b0, node_q, 1'b1};
	assign ridx = lidx + 1'b1;

	always_comb begin
		top_idx = {1'b0, 1'b0, node_q};
		top_val = nval_q;
		if (lidx < {1'b0, heap_q} && rd_a_q > top_val) begin
			top_idx = lidx;
			top_val = rd_a_q;
		end
		if (ridx < {1'b0, heap_q} && rd_b_q > top_val) begin
			top_idx = ridx;
			top_val = rd_b_q;
		end
		moved = (top_idx != {1'b0, 1'b0, node_q});
	end

	always_comb begin
		case (uw.cond)
			C_NEVER:     jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_NOT_CLOSE: jump = !(item_acc && item.last);
			C_I_ZERO:    jump = (i_q == '0);
			C_MOVED:     jump = moved;
			C_OUT_BUSY:  jump = result_valid_q && !result_ready;
			C_MORE:      jump = (CNT_W'(i_q + 1'b1) < cnt_q);
			default:     jump = 1'b0;
		endcase
	end

	// memory ports
	always_comb begin
		raddr_a = '0;
		raddr_b = '0;
		we      = 1'b0;
		waddr   = '0;
		wdata   = '0;
		case (uw.op)
			OP_COLLECT: begin
				we    = item_acc && (cnt_q < CNT_W'(MAX_ELEMENTS));
				waddr = cnt_q[IDX_W-1:0];
				wdata = item.value;
			end
			OP_BREAD: raddr_a = IDX_W'(i_q - 1'b1);
			OP_SREAD: begin
				raddr_a = lidx[IDX_W-1:0];
				raddr_b = ridx[IDX_W-1:0];
			end
			OP_SCMP: begin
				// hole sift: the held value lands only where the descent stops
				we    = 1'b1;
				waddr = node_q;
				wdata = top_val;
			end
			OP_SWAPRD: begin
				raddr_a = '0;
				raddr_b = i_q[IDX_W-1:0];
			end
			OP_SWAPWR: begin
				we    = 1'b1;
				waddr = i_q[IDX_W-1:0];
				wdata = rd_a_q;
			end
			OP_ORD:  raddr_a = i_q[IDX_W-1:0];
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	always_ff @(posedge clk) begin
		case (uw.op)
			OP_LOADN:  nval_q <= rd_a_q;
			OP_SWAPWR: nval_q <= rd_b_q;
			default:   nval_q <= nval_q;
		endcase
		if (uw.op == OP_OLOAD) begin
			result_q.sorted_value <= rd_a_q;
			result_q.final_res    <= (CNT_W'(i_q + 1'b1) == cnt_q);
			result_q.overflowed   <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q           <= S_COLLECT;
			cnt_q          <= '0;
			ovf_q          <= 1'b0;
			i_q            <= '0;
			heap_q         <= '0;
			node_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			pc_q <= jump ? uw.target : pc_q + 1'b1;
			if (take) begin
				result_valid_q <= 1'b0;
			end
			case (uw.op)
				OP_COLLECT: begin
					if (item_acc) begin
						if (cnt_q < CNT_W'(MAX_ELEMENTS)) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				OP_BINIT: begin
					i_q    <= cnt_q >> 1;
					heap_q <= cnt_q;
				end
				OP_BREAD: begin
					node_q <= IDX_W'(i_q - 1'b1);
					i_q    <= i_q - 1'b1;
				end
				OP_SCMP: begin
					if (moved) begin
						node_q <= top_idx[IDX_W-1:0];
					end
				end
				OP_SINIT: i_q <= cnt_q - 1'b1;
				OP_SWAPRD: begin
					heap_q <= i_q;
					node_q <= '0;
				end
				OP_SWAPWR: i_q <= i_q - 1'b1;
				OP_OINIT:  i_q <= '0;
				OP_OLOAD:  result_valid_q <= 1'b1;
				OP_ONEXT:  i_q <= i_q + 1'b1;
				OP_CLEAR: begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == S_OLOAD) |-> !result_valid_q)
		else $error("result register overwritten while still holding a result");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ELEMENTS))
		else $error("element count beyond store depth");

	a_node_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == S_BSCMP || pc_q == S_SSCMP) |-> ({1'b0, node_q} < heap_q))
		else $error("sift node outside the heap");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q != S_COLLECT && pc_q != S_CLEAR) |=> $stable(cnt_q))
		else $error("element count changed during sort");
`endif

endmodule
